// ===== rtl/ots_pkg.sv =====
// ----------------------------------------------------------------------------
// ots_pkg
// Shared types and constants for the oscillator trim search.
// ----------------------------------------------------------------------------
package ots_pkg;

   localparam int unsigned TrimWidth   = 8;
   localparam int unsigned LengthWidth = 16;

   localparam logic [LengthWidth-1:0] TargetReset = 16'd2356;
   localparam logic [TrimWidth-1:0]   FirstStep   = 8'd128;
   localparam logic [TrimWidth-1:0]   TrimMax     = 8'd255;

   // Request kinds carried on the request tuser bit.
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_MEASURE = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_BINARY   = 2'd1,
      PH_NEIGHBOR = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type               phase;
      logic [TrimWidth-1:0]    step_size;
      logic [TrimWidth-1:0]    search_base;
      logic [TrimWidth-1:0]    current_trim;
      logic [TrimWidth-1:0]    neighbor_end;
      logic [TrimWidth-1:0]    best_trim;
      logic [LengthWidth-1:0]  best_deviation;
   } search_state_type;

   typedef struct packed {
      logic                    emit;
      logic [TrimWidth-1:0]    trim_value;
      logic                    done_res;
   } step_result_type;

endpackage

// ===== rtl/ots_step.sv =====
// ----------------------------------------------------------------------------
// ots_step
// Next-state and result logic for one request against the search state.
// ----------------------------------------------------------------------------
module ots_step
   import ots_pkg::*;
(
   input  search_state_type       state_cur,
   input  logic                   command,
   input  logic [LengthWidth-1:0] frame_length,
   input  logic [LengthWidth-1:0] target_length,
   output search_state_type       state_nxt,
   output step_result_type        result
);

   logic [LengthWidth:0]   diff;
   logic                   below;
   logic [LengthWidth-1:0] deviation;
   logic [TrimWidth-1:0]   base_upd;
   logic [TrimWidth-1:0]   step_upd;
   logic                   improve;
   logic [TrimWidth-1:0]   best_upd;

   // Borrow of the subtraction tells whether the measurement is short.
   assign diff      = {1'b0, frame_length} - {1'b0, target_length};
   assign below     = diff[LengthWidth];
   assign deviation = below ? (target_length - frame_length) : diff[LengthWidth-1:0];

   assign base_upd  = below ? (state_cur.search_base + state_cur.step_size)
                            : state_cur.search_base;
   assign step_upd  = state_cur.step_size >> 1;

   assign improve   = deviation < state_cur.best_deviation;
   assign best_upd  = improve ? state_cur.current_trim : state_cur.best_trim;

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      if (command == CMD_START) begin
         state_nxt.phase        = PH_BINARY;
         state_nxt.step_size    = FirstStep;
         state_nxt.search_base  = '0;
         state_nxt.current_trim = FirstStep;
         result.emit            = 1'b1;
         result.trim_value      = FirstStep;
      end else begin
         case (state_cur.phase)
            PH_BINARY: begin
               state_nxt.search_base = base_upd;
               state_nxt.step_size   = step_upd;
               result.emit           = 1'b1;
               if (step_upd != '0) begin
                  state_nxt.current_trim = base_upd + step_upd;
               end else begin
                  // Seed the best entry with the raw last measurement.
                  state_nxt.best_trim      = base_upd;
                  state_nxt.best_deviation = frame_length;
                  state_nxt.current_trim   = (base_upd == '0) ? '0 : base_upd - 1'b1;
                  state_nxt.neighbor_end   = (base_upd == TrimMax) ? TrimMax
                                                                   : base_upd + 1'b1;
                  state_nxt.phase          = PH_NEIGHBOR;
               end
               result.trim_value = state_nxt.current_trim;
            end
            PH_NEIGHBOR: begin
               result.emit = 1'b1;
               if (improve) begin
                  state_nxt.best_deviation = deviation;
                  state_nxt.best_trim      = state_cur.current_trim;
               end
               if (state_cur.current_trim >= state_cur.neighbor_end) begin
                  state_nxt.phase   = PH_IDLE;
                  result.trim_value = best_upd;
                  result.done_res   = 1'b1;
               end else begin
                  state_nxt.current_trim = state_cur.current_trim + 1'b1;
                  result.trim_value      = state_cur.current_trim + 1'b1;
               end
            end
            default: begin
               // Idle or unused code: drop the measurement, hold the state.
               result.emit = 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== rtl/oscillator_trim_search.sv =====
// ----------------------------------------------------------------------------
// oscillator_trim_search
// Successive-approximation search for an 8-bit oscillator trim value.
// ----------------------------------------------------------------------------
// A start transaction (tuser 0) begins an 8-step binary search and answers
// with the first trim to apply (128). Every measurement transaction (tuser 1)
// carries the frame length seen at the trim last given and is answered with
// the next trim. After the binary search, the three neighbors of the result
// (clamped to 0..255) are measured and the trim closest to target_length is
// returned with done set. Measurements while idle are dropped with no answer.
// Throughput is one transaction per cycle while responses are taken; each
// request passes the request register, the combinational step logic and
// the response register, which decouples a stalled consumer from the input
// side for one transaction. Write target_length only while the block is idle.
// ----------------------------------------------------------------------------
module oscillator_trim_search
   import ots_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [LengthWidth-1:0] req_tdata,   // [15:0] frame_length
   input  logic                   req_tuser,   // [0] command
   // Response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TrimWidth-1:0]   rsp_tdata,   // [7:0] trim_value
   output logic                   rsp_tuser,   // [0] done_res
   // Target register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LengthWidth-1:0] csr_data     // [15:0] target_length
);

   logic [LengthWidth-1:0] target_ff;
   logic [LengthWidth-1:0] target_in;

   logic                   req_valid_ff;
   logic                   req_valid_in;
   logic                   req_cmd_ff;
   logic [LengthWidth-1:0] req_len_ff;

   search_state_type       state_ff;
   search_state_type       state_in;
   search_state_type       state_step;
   step_result_type        step_res;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [TrimWidth-1:0]   rsp_trim_ff;
   logic                   rsp_done_ff;

   logic                   advance;

   // Target register: always ready; the user must write it only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;
   assign target_in = (csr_valid && csr_ready) ? csr_data : target_ff;

   // Retire the held request when the response slot is free or draining.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   assign req_valid_in = (req_tvalid && req_tready) ? 1'b1
                                                    : (advance ? 1'b0 : req_valid_ff);

   ots_step u_step (
      .state_cur     (state_ff),
      .command       (req_cmd_ff),
      .frame_length  (req_len_ff),
      .target_length (target_ff),
      .state_nxt     (state_step),
      .result        (step_res)
   );

   assign state_in = advance ? state_step : state_ff;

   // Load the response slot on an emitting step, drop it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && step_res.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TargetReset;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, best_deviation: '1, default: '0};
      end else begin
         target_ff    <= target_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_cmd_ff <= req_tuser;
         req_len_ff <= req_tdata;
      end
      if (advance && step_res.emit) begin
         rsp_trim_ff <= step_res.trim_value;
         rsp_done_ff <= step_res.done_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_trim_ff;
   assign rsp_tuser  = rsp_done_ff;

   // A done response always leaves the search idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && step_res.emit && step_res.done_res) |=> (state_ff.phase == PH_IDLE))
      else $error("search not idle after done response");

   // The binary search step is always a single bit.
   a_step_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_BINARY) |-> $onehot(state_ff.step_size))
      else $error("binary step size not one-hot");

   // Neighborhood trial never passes its end.
   a_neighbor_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_NEIGHBOR) |-> (state_ff.current_trim <= state_ff.neighbor_end))
      else $error("neighborhood trial past its end");

   // A new response only appears from a retired request.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("response without retired request");

   // State moves only when a request retires.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("search state changed without a request");

endmodule

// ===== verif/oscillator_trim_search_test.sv =====
// ----------------------------------------------------------------------------
// oscillator_trim_search_test
// Self-checking bench for the oscillator trim search sequencer.
// ----------------------------------------------------------------------------
// Calibration runs are queued as whole transaction sequences: a start, eight
// binary-search measurements and the two or three neighborhood measurements
// that follow. Some runs are cut short by a new start, and some are trailed by
// stray measurements that the block must drop. A clocked driver feeds the
// request channel from the run queue, and every accepted request is pushed
// through a local model of the search that queues the trim it should answer
// with. A clocked monitor compares each response with the oldest queued trim.
// The target register is rewritten between phases, once all answers are in,
// and walks through its extremes. Both sides idle in random bursts, the
// response side holds off once for a long stretch, and the final phase runs
// at full rate.
// ----------------------------------------------------------------------------
module oscillator_trim_search_test;
   import ots_pkg::*;

   localparam int unsigned ItemGoal     = 1300;
   localparam int unsigned CalsPerPhase = 10;
   localparam int unsigned CalmAfter    = 1100;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned HoldCycles   = 400;
   localparam int unsigned HoldAfter    = 200;
   localparam int unsigned CycleLimit   = 500000;
   localparam int unsigned ReportLimit  = 10;

   typedef struct {
      logic                   cmd;
      logic [LengthWidth-1:0] frame_len;
   } meas_item_type;

   typedef struct {
      logic [TrimWidth-1:0] trim;
      logic                 done;
   } trim_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [LengthWidth-1:0] req_tdata  = '0;
   logic                   req_tuser  = CMD_START;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TrimWidth-1:0]   rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [LengthWidth-1:0] csr_data   = '0;

   oscillator_trim_search DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] frame_length
      .req_tuser  (req_tuser),    // [0] command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] trim_value
      .rsp_tuser  (rsp_tuser),    // [0] done_res
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)      // [15:0] target_length
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Requests waiting to be driven, and trims the block still owes us.
   meas_item_type   cal_queue[$];
   trim_answer_type trims_due[$];

   int unsigned stim_count     = 0;
   int unsigned sent_count     = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned req_gap_odds   = 0;
   int unsigned rsp_gap_odds   = 0;
   int unsigned gap_left       = 0;
   int unsigned stall_left     = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;

   meas_item_type   next_item;
   trim_answer_type due;

   // Local copy of the search state and the target register.
   logic [LengthWidth-1:0] sr_target;
   phase_type              sr_phase;
   logic [TrimWidth-1:0]   sr_step;
   logic [TrimWidth-1:0]   sr_base;
   logic [TrimWidth-1:0]   sr_trial;
   logic [TrimWidth-1:0]   sr_last;
   logic [TrimWidth-1:0]   sr_best;
   logic [LengthWidth-1:0] sr_best_dev;

   // Advance the search by one accepted request and queue the trim it yields.
   task automatic step_trim_search(input logic cmd, input logic [LengthWidth-1:0] len);
      logic [LengthWidth-1:0] dev;
      if (cmd == CMD_START) begin
         sr_step  = FirstStep;
         sr_base  = '0;
         sr_trial = FirstStep;
         sr_phase = PH_BINARY;
         trims_due.push_back('{sr_trial, 1'b0});
      end else begin
         case (sr_phase)
            PH_BINARY: begin
               // Keep the step bit when the oscillator still runs short.
               if (len < sr_target) sr_base = sr_base + sr_step;
               sr_step = sr_step >> 1;
               if (sr_step != '0) begin
                  sr_trial = sr_base + sr_step;
               end else begin
                  // Seed the best with the raw length, not a deviation.
                  sr_best     = sr_base;
                  sr_best_dev = len;
                  sr_trial    = (sr_base == '0) ? '0 : sr_base - 1'b1;
                  sr_last     = (sr_base == TrimMax) ? TrimMax : sr_base + 1'b1;
                  sr_phase    = PH_NEIGHBOR;
               end
               trims_due.push_back('{sr_trial, 1'b0});
            end
            PH_NEIGHBOR: begin
               dev = (len >= sr_target) ? len - sr_target : sr_target - len;
               // Strictly smaller only: the earlier trim wins a tie.
               if (dev < sr_best_dev) begin
                  sr_best_dev = dev;
                  sr_best     = sr_trial;
               end
               if (sr_trial >= sr_last) begin
                  sr_phase = PH_IDLE;
                  trims_due.push_back('{sr_best, 1'b1});
               end else begin
                  sr_trial = sr_trial + 1'b1;
                  trims_due.push_back('{sr_trial, 1'b0});
               end
            end
            default: ;   // idle: drop the measurement
         endcase
      end
   endtask

   task automatic push_item(input logic cmd, input logic [LengthWidth-1:0] len,
                            input bit counted);
      cal_queue.push_back('{cmd, len});
      if (counted) stim_count++;
   endtask

   // Frame length on the requested side of the target, mostly close to it.
   function automatic logic [LengthWidth-1:0] pick_length(input bit below, input int tgt);
      int span;
      if (below && tgt > 0) begin
         if ($urandom_range(0, 3) == 0) return LengthWidth'($urandom_range(0, tgt - 1));
         span = (tgt < 64) ? tgt : 64;
         return LengthWidth'(tgt - $urandom_range(1, span));
      end
      if ($urandom_range(0, 3) == 0) return LengthWidth'($urandom_range(tgt, 65535));
      span = (65535 - tgt < 64) ? 65535 - tgt : 64;
      return LengthWidth'(tgt + $urandom_range(0, span));
   endfunction

   // Neighborhood length: small deviations so that ties come up often.
   function automatic logic [LengthWidth-1:0] near_length(input int tgt);
      int d;
      if ($urandom_range(0, 7) == 0) return LengthWidth'($urandom_range(0, 65535));
      d = $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 1 && tgt + d <= 65535) return LengthWidth'(tgt + d);
      if (tgt >= d) return LengthWidth'(tgt - d);
      return LengthWidth'(tgt + d);
   endfunction

   // Queue one complete calibration; a cut run is restarted by the next start.
   task automatic queue_calibration();
      int   base;
      int   mode;
      bit   below;
      bit   cut;
      logic [LengthWidth-1:0] len;
      do begin
         cut  = 1'b0;
         base = 0;
         mode = $urandom_range(0, 9);
         push_item(CMD_START, LengthWidth'($urandom_range(0, 65535)), 1'b1);
         for (int k = 0; k < 8 && !cut; k++) begin
            // Steer some runs to the bottom or top trim to hit the clamps.
            below = (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            len   = pick_length(below, int'(sr_target));
            if (len < sr_target) base += 128 >> k;
            push_item(CMD_MEASURE, len, 1'b1);
            if ($urandom_range(0, 39) == 0) cut = 1'b1;
         end
      end while (cut);
      for (int n = 0; n < ((base == 0 || base == 255) ? 2 : 3); n++)
         push_item(CMD_MEASURE, near_length(int'(sr_target)), 1'b1);
      // Stray measurement after the answer: the block must drop it.
      if ($urandom_range(0, 15) == 0)
         push_item(CMD_MEASURE, LengthWidth'($urandom_range(0, 65535)), 1'b0);
   endtask

   // Wait until every request is taken and every trim has come back.
   task automatic wait_drained();
      while (cal_queue.size() != 0 || req_tvalid || trims_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_target(input logic [LengthWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      sr_target = value;
   endtask

   // Request driver: hold an offered transaction until taken, then idle or advance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_trim_search(req_tuser, req_tdata);
            sent_count <= sent_count + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered transaction
         end else if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
            gap_left   <= $urandom_range(0, 9);
            req_tvalid <= 1'b0;
         end else if (cal_queue.size() != 0) begin
            next_item   = cal_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.frame_len;
            req_tuser  <= next_item.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long hold-off on the response side, once, so the request side backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && sent_count >= HoldAfter) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end
   end

   // Response monitor: check each transaction against the oldest owed trim.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (trims_due.size() == 0) begin
               if (mismatch_count < ReportLimit)
                  $display("unexpected response: trim %0d done %0b", rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               due = trims_due.pop_front();
               if (rsp_tdata !== due.trim || rsp_tuser !== due.done) begin
                  if (mismatch_count < ReportLimit)
                     $display("mismatch: trim exp %0d got %0d, done exp %0b got %0b",
                              due.trim, rsp_tdata, due.done, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_gap_odds != 0 && $urandom_range(1, rsp_gap_odds) == 1) begin
            stall_left <= $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned phase_idx;
      logic [LengthWidth-1:0] extremes[5];
      extremes = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, TargetReset};
      sr_target   = TargetReset;
      sr_phase    = PH_IDLE;
      sr_step     = '0;
      sr_base     = '0;
      sr_trial    = '0;
      sr_last     = '0;
      sr_best     = '0;
      sr_best_dev = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset target of 2356.
      push_item(CMD_MEASURE, 16'hFFFF, 1'b0);   // measurement while idle
      push_item(CMD_START, 16'd0, 1'b1);
      push_item(CMD_MEASURE, 16'd100, 1'b1);
      push_item(CMD_MEASURE, 16'd3000, 1'b1);
      push_item(CMD_START, 16'hFFFF, 1'b1);     // start while busy
      // Never below target: bottom trim, neighborhood clamped to 0..1.
      push_item(CMD_MEASURE, 16'hFFFF, 1'b1);
      push_item(CMD_MEASURE, 16'd2356, 1'b1);
      push_item(CMD_MEASURE, 16'd2357, 1'b1);
      push_item(CMD_MEASURE, 16'd40000, 1'b1);
      push_item(CMD_MEASURE, 16'd2356, 1'b1);
      push_item(CMD_MEASURE, 16'd2356, 1'b1);
      push_item(CMD_MEASURE, 16'd2356, 1'b1);
      push_item(CMD_MEASURE, 16'd2400, 1'b1);
      push_item(CMD_MEASURE, 16'd2350, 1'b1);   // equal deviations: trim 0 stays
      push_item(CMD_MEASURE, 16'd2362, 1'b1);
      // Always below target: top trim, neighborhood clamped to 254..255.
      push_item(CMD_START, 16'd0, 1'b1);
      push_item(CMD_MEASURE, 16'd0, 1'b1);
      push_item(CMD_MEASURE, 16'd2355, 1'b1);
      push_item(CMD_MEASURE, 16'd1, 1'b1);
      push_item(CMD_MEASURE, 16'd1000, 1'b1);
      push_item(CMD_MEASURE, 16'd2000, 1'b1);
      push_item(CMD_MEASURE, 16'd2355, 1'b1);
      push_item(CMD_MEASURE, 16'd2300, 1'b1);
      push_item(CMD_MEASURE, 16'd5, 1'b1);
      push_item(CMD_MEASURE, 16'd2360, 1'b1);
      push_item(CMD_MEASURE, 16'd2352, 1'b1);
      wait_drained();

      // Random phases: extremes of the target first, then random targets.
      phase_idx = 0;
      while (stim_count < ItemGoal) begin
         write_target((phase_idx < 5) ? extremes[phase_idx]
                                      : LengthWidth'($urandom_range(0, 65535)));
         if (stim_count >= CalmAfter) begin
            req_gap_odds = 0;
            rsp_gap_odds = 0;
         end else begin
            req_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
            rsp_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
         end
         repeat (CalsPerPhase) queue_calibration();
         wait_drained();
         phase_idx++;
      end

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
